// ----- design/frame_reorder_gap_fill_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the frame resequencer
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef FRAME_REORDER_GAP_FILL_MACROS_SVH
`define FRAME_REORDER_GAP_FILL_MACROS_SVH

// Same-cycle implication.
`define FRG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("frame resequencer: same-cycle check failed");

// Next-cycle implication.
`define FRG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("frame resequencer: next-cycle check failed");

`endif

// ----- design/frg_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame resequencer package
// Types, codes and defaults shared by the resequencer and its tag RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package frg_pkg;

    localparam int WINDOW_DEF = 16;
    localparam int ID_W       = 32;
    localparam int TAG_W      = 16;
    localparam int GAP_W      = 4;

    localparam logic [GAP_W-1:0] MAX_GAP_RESET = 4'd4;

    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef enum logic [2:0] {
        KIND_FRAME    = 3'd0,
        KIND_FILLER   = 3'd1,
        KIND_STALE    = 3'd2,
        KIND_BEYOND   = 3'd3,
        KIND_BUFFERED = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_WALK
    } state_t;

    typedef struct packed {
        logic             command;
        logic [ID_W-1:0]  seq_num;
        logic [TAG_W-1:0] payload_tag;
    } in_beat_t;

    typedef struct packed {
        logic [ID_W-1:0]  out_id;
        kind_t            kind;
        logic [TAG_W-1:0] out_tag;
        logic             last;
    } out_beat_t;

endpackage

// ----- design/frg_tag_ram.sv -----
// ----------------------------------------------------------------------------
// Frame tag RAM
// One write port and one registered read port holding payload tags by slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frg_tag_ram #(
    parameter int DEPTH  = frg_pkg::WINDOW_DEF,
    parameter int ADDR_W = $clog2(frg_pkg::WINDOW_DEF)
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [ADDR_W-1:0]        waddr,
    input  logic [frg_pkg::TAG_W-1:0] wdata,
    input  logic                     re,
    input  logic [ADDR_W-1:0]        raddr,
    output logic [frg_pkg::TAG_W-1:0] rdata
);

    logic [frg_pkg::TAG_W-1:0] mem [DEPTH];
    logic [frg_pkg::TAG_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds until the next read, so a stalled result keeps its tag.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/frame_reorder_gap_fill.sv -----
// ----------------------------------------------------------------------------
// frame_reorder_gap_fill: frame resequencer with gap fill
// Flow: a stale or out-of-window beat is flagged in the check state and passes
//   through the pending entry to the output register; a beat that is only
//   buffered is written to the tag RAM and reported from the scan state;
//   otherwise the walk state reads the tag RAM and gives one result a cycle
//   while the output does not stall. A new beat is accepted only in idle with
//   no result pending.
// Reset: synchronous, active-low aresetn clears the expected id, slot valid
//   flags and control; max_gap returns to 4. The tag RAM is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "frame_reorder_gap_fill_macros.svh"

module frame_reorder_gap_fill #(
    parameter int WINDOW = frg_pkg::WINDOW_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  frg_pkg::in_beat_t         s_data,

    output logic                      m_valid,
    input  logic                      m_ready,
    output frg_pkg::out_beat_t        m_data,

    input  logic                      max_gap_we,
    input  logic [frg_pkg::GAP_W-1:0] max_gap_wdata
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int CMP_W  = (SLOT_W > frg_pkg::GAP_W) ? SLOT_W : frg_pkg::GAP_W;

    // State and registers
    frg_pkg::state_t               state_reg, state_next;
    frg_pkg::in_beat_t             item_reg;
    logic [frg_pkg::ID_W-1:0]      expected_reg;
    logic [SLOT_W-1:0]             exp_slot_reg;
    logic [WINDOW-1:0]             slot_valid_reg;
    logic [CNT_W-1:0]              forced_reg;
    logic [frg_pkg::GAP_W-1:0]     max_gap_reg;

    logic                          pend_valid_reg;
    logic [frg_pkg::ID_W-1:0]      pend_id_reg;
    frg_pkg::kind_t                pend_kind_reg;
    logic                          pend_last_reg;

    logic                          m_valid_reg;
    frg_pkg::out_beat_t            m_data_reg;

    // Check stage
    logic                          stale;
    logic                          beyond;
    logic [frg_pkg::ID_W-1:0]      off;
    logic [SLOT_W:0]               slot_sum;
    logic [SLOT_W-1:0]             in_slot;

    // Scan stage
    logic [WINDOW-1:0]             rot;
    logic [SLOT_W-1:0]             first_off;
    logic [SLOT_W-1:0]             high_off;
    logic                          any_valid;
    logic                          gap_hit;
    logic [CNT_W-1:0]              forced_val;
    logic                          scan_walk;

    // Walk stage
    logic                          cur_valid;
    logic [SLOT_W-1:0]             next_slot;
    logic [CNT_W-1:0]              forced_after;
    logic                          walk_more;

    // Control
    logic                          pend_move;
    logic                          pend_free;
    logic                          push;
    logic [frg_pkg::ID_W-1:0]      push_id;
    frg_pkg::kind_t                push_kind;
    logic                          push_last;
    logic                          walk_go;
    logic                          mem_we;
    logic                          load_forced;
    logic [frg_pkg::TAG_W-1:0]     rd_tag;

    assign s_ready   = (state_reg == frg_pkg::ST_IDLE) && !pend_valid_reg;
    assign pend_move = pend_valid_reg && (!m_valid_reg || m_ready);
    assign pend_free = !pend_valid_reg || pend_move;

    // Window and slot of an arriving frame.
    always_comb begin
        stale    = item_reg.seq_num < expected_reg;
        off      = item_reg.seq_num - expected_reg;
        beyond   = off >= 32'(WINDOW);
        slot_sum = {1'b0, exp_slot_reg} + {1'b0, off[SLOT_W-1:0]};
        if (slot_sum >= (SLOT_W+1)'(WINDOW)) begin
            in_slot = SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW));
        end else begin
            in_slot = slot_sum[SLOT_W-1:0];
        end
    end

    // Valid flags rotated so that bit k stands for id expected + k.
    always_comb begin
        logic [SLOT_W:0] idx_sum;
        for (int k = 0; k < WINDOW; k++) begin
            idx_sum = {1'b0, exp_slot_reg} + (SLOT_W+1)'(k);
            if (idx_sum >= (SLOT_W+1)'(WINDOW)) begin
                idx_sum = idx_sum - (SLOT_W+1)'(WINDOW);
            end
            rot[k] = slot_valid_reg[idx_sum[SLOT_W-1:0]];
        end
    end

    always_comb begin
        first_off = '0;
        for (int k = WINDOW - 1; k >= 0; k--) begin
            if (rot[k]) begin
                first_off = SLOT_W'(k);
            end
        end
        high_off = '0;
        for (int k = 0; k < WINDOW; k++) begin
            if (rot[k]) begin
                high_off = SLOT_W'(k);
            end
        end
        any_valid = |slot_valid_reg;
        gap_hit   = CMP_W'(first_off) > CMP_W'(max_gap_reg);
        if (item_reg.command == frg_pkg::CMD_FLUSH) begin
            forced_val = any_valid ? (CNT_W'(high_off) + CNT_W'(1)) : '0;
        end else begin
            forced_val = gap_hit ? CNT_W'(first_off) : '0;
        end
        scan_walk = (forced_val != '0) || rot[0];
    end

    // One walk step: emit the frame at the expected id or a filler for it.
    always_comb begin
        cur_valid    = slot_valid_reg[exp_slot_reg];
        next_slot    = (exp_slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : exp_slot_reg + SLOT_W'(1);
        forced_after = (forced_reg != '0) ? forced_reg - CNT_W'(1) : forced_reg;
        walk_more    = (forced_after != '0) || slot_valid_reg[next_slot];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            frg_pkg::ST_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next = frg_pkg::ST_CHECK;
                end
            end
            frg_pkg::ST_CHECK: begin
                if (item_reg.command == frg_pkg::CMD_FRAME && (stale || beyond)) begin
                    state_next = frg_pkg::ST_IDLE;
                end else begin
                    state_next = frg_pkg::ST_SCAN;
                end
            end
            frg_pkg::ST_SCAN: begin
                state_next = scan_walk ? frg_pkg::ST_WALK : frg_pkg::ST_IDLE;
            end
            frg_pkg::ST_WALK: begin
                if (walk_go && !walk_more) begin
                    state_next = frg_pkg::ST_IDLE;
                end
            end
            default: state_next = frg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        push        = 1'b0;
        push_id     = item_reg.seq_num;
        push_kind   = frg_pkg::KIND_BUFFERED;
        push_last   = 1'b1;
        walk_go     = 1'b0;
        mem_we      = 1'b0;
        load_forced = 1'b0;
        unique case (state_reg)
            frg_pkg::ST_IDLE: begin
            end
            frg_pkg::ST_CHECK: begin
                if (item_reg.command == frg_pkg::CMD_FRAME) begin
                    if (stale) begin
                        push      = 1'b1;
                        push_kind = frg_pkg::KIND_STALE;
                    end else if (beyond) begin
                        push      = 1'b1;
                        push_kind = frg_pkg::KIND_BEYOND;
                    end else begin
                        mem_we = 1'b1;
                    end
                end
            end
            frg_pkg::ST_SCAN: begin
                load_forced = 1'b1;
                if (!scan_walk && item_reg.command == frg_pkg::CMD_FRAME) begin
                    push = 1'b1;
                end
            end
            frg_pkg::ST_WALK: begin
                if (pend_free) begin
                    walk_go   = 1'b1;
                    push      = 1'b1;
                    push_id   = expected_reg;
                    push_kind = cur_valid ? frg_pkg::KIND_FRAME : frg_pkg::KIND_FILLER;
                    push_last = !walk_more;
                end
            end
            default: begin
            end
        endcase
    end

    frg_tag_ram #(
        .DEPTH  (WINDOW),
        .ADDR_W (SLOT_W)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (in_slot),
        .wdata (item_reg.payload_tag),
        .re    (walk_go),
        .raddr (exp_slot_reg),
        .rdata (rd_tag)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= frg_pkg::ST_IDLE;
            expected_reg   <= '0;
            exp_slot_reg   <= '0;
            slot_valid_reg <= '0;
            forced_reg     <= '0;
            max_gap_reg    <= frg_pkg::MAX_GAP_RESET;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (max_gap_we) begin
                max_gap_reg <= max_gap_wdata;
            end
            if (mem_we) begin
                slot_valid_reg[in_slot] <= 1'b1;
            end
            if (load_forced) begin
                forced_reg <= forced_val;
            end
            if (walk_go) begin
                slot_valid_reg[exp_slot_reg] <= 1'b0;
                expected_reg                 <= expected_reg + 32'd1;
                exp_slot_reg                 <= next_slot;
                forced_reg                   <= forced_after;
            end
            if (push) begin
                pend_valid_reg <= 1'b1;
            end else if (pend_move) begin
                pend_valid_reg <= 1'b0;
            end
            if (pend_move) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        if (push) begin
            pend_id_reg   <= push_id;
            pend_kind_reg <= push_kind;
            pend_last_reg <= push_last;
        end
        // The tag read for a frame beat lands together with its pending entry.
        if (pend_move) begin
            m_data_reg.out_id  <= pend_id_reg;
            m_data_reg.kind    <= pend_kind_reg;
            m_data_reg.out_tag <= (pend_kind_reg == frg_pkg::KIND_FRAME) ? rd_tag : '0;
            m_data_reg.last    <= pend_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `FRG_ASSERT_IMPL(a_walk_has_work, state_reg == frg_pkg::ST_WALK, (forced_reg != '0) || slot_valid_reg[exp_slot_reg])
    `FRG_ASSERT_IMPL(a_last_ends_walk, pend_valid_reg && pend_last_reg, state_reg == frg_pkg::ST_IDLE)
    `FRG_ASSERT_NEXT(a_idle_keeps_valid, state_reg == frg_pkg::ST_IDLE, $stable(slot_valid_reg))
    `FRG_ASSERT_IMPL(a_slot_in_range, 1'b1, {1'b0, exp_slot_reg} < (SLOT_W+1)'(WINDOW))

endmodule
